// ----- src/alm_pkg.sv -----
// ----------------------------------------------------------------------------
// alm_pkg
// Shared types and constants for the array linked list manager.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int NODE_COUNT_DEF = 128;
  localparam int PTR_W          = 8;
  localparam int VAL_W          = 32;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t NULL_LINK = 8'hFF;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS_FREE,
    S_WALK,
    S_INS_PREV,
    S_INS_LINK,
    S_RD_DATA,
    S_REM_HEAD,
    S_REM_GONE,
    S_REM_NEXT,
    S_REM_FREE,
    S_DONE
  } state_t;

  // one write and one read port of the link store
  typedef struct packed {
    logic we;
    ptr_t waddr;
    ptr_t wdata;
    ptr_t raddr;
  } link_req_t;

endpackage

// ----- src/alm_ram.sv -----
// ----------------------------------------------------------------------------
// alm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module alm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/alm_link_store.sv -----
// ----------------------------------------------------------------------------
// alm_link_store
// Link memory with per-entry valid bits; an entry never written reads as its
// reset link (next node, null for the last node).
// ----------------------------------------------------------------------------
module alm_link_store #(
  parameter int NODE_COUNT = alm_pkg::NODE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  alm_pkg::link_req_t req,
  output alm_pkg::ptr_t     rdata
);

  import alm_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);

  logic [NODE_COUNT-1:0] valid_r;
  logic [NODE_COUNT-1:0] valid_nxt;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         raddr_r;
  logic                  rvalid_r;
  ptr_t                  ram_q;
  ptr_t                  reset_link;

  assign waddr = req.waddr[AW-1:0];
  assign raddr = req.raddr[AW-1:0];

  alm_ram #(
    .WIDTH (PTR_W),
    .DEPTH (NODE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (waddr),
    .wdata (req.wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (req.we) begin
      valid_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // valid bit sampled alongside the RAM read (old value on collision)
  always_ff @(posedge clk) begin
    raddr_r  <= raddr;
    rvalid_r <= valid_r[raddr];
  end

  assign reset_link = (raddr_r == AW'(NODE_COUNT - 1)) ? NULL_LINK
                                                        : ptr_t'(raddr_r) + ptr_t'(1);
  assign rdata      = rvalid_r ? ram_q : reset_link;

endmodule

// ----- src/array_linked_list_manager.sv -----
// ----------------------------------------------------------------------------
// array_linked_list_manager
// Singly linked list in a fixed node store with a free list.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser carries the command (insert, read, remove, query),
//   in_tdata the 1-based position and the value to insert. One result per
//   request on the output stream: read value, length after the request,
//   empty flag and status (ok, bad position, store full).
//   A request is taken only while the sequencer is idle. The result is
//   registered after the check step for a query or a rejected request,
//   after one more step for an insert or remove at the head, and after a
//   walk for insert and remove elsewhere and for read: the walk follows
//   one link per cycle through the read port of the link memory.
//   The result sits in an output register; the next request is accepted
//   while it waits, but a finished request holds in the last step until the
//   output register is free, so a stalled receiver stops the block.
//   Reset empties the list and puts every node on the free list; the link
//   memory uses per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module array_linked_list_manager #(
  parameter int NODE_COUNT = alm_pkg::NODE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[7:0], item_value[39:8]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_value[31:0], list_length[39:32],
                                  // is_empty[40], status[42:41], zero[47:43]
);

  import alm_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);

  state_t     state_r, state_nxt;
  cmd_t       cmd_r, cmd_nxt;
  ptr_t       pos_r, pos_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  ptr_t       head_r, head_nxt;
  ptr_t       free_r, free_nxt;
  ptr_t       count_r, count_nxt;
  ptr_t       node_r, node_nxt;
  ptr_t       gone_r, gone_nxt;
  ptr_t       steps_r, steps_nxt;
  logic       first_r, first_nxt;
  logic [VAL_W-1:0] rd_r, rd_nxt;
  status_t    status_r, status_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r, out_data_nxt;

  link_req_t  link_req;
  ptr_t       link_rdata;
  logic       val_we;
  ptr_t       val_waddr;
  ptr_t       val_raddr;
  logic [VAL_W-1:0] val_rdata;

  logic       accept;
  logic       out_free;
  logic       pos_zero;
  logic       pos_one;
  logic       pos_gt_cnt;
  logic       pos_gt_cnt1;
  logic       bad_ins;
  logic       bad_pos;
  logic       full;
  ptr_t       cur;

  assign accept      = in_tvalid && in_tready;
  assign in_tready   = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_tready;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;

  assign pos_zero    = (pos_r == '0);
  assign pos_one     = (pos_r == ptr_t'(1));
  assign pos_gt_cnt  = ({1'b0, pos_r} > {1'b0, count_r});
  assign pos_gt_cnt1 = ({1'b0, pos_r} > ({1'b0, count_r} + 9'd1));
  assign bad_ins     = pos_zero || pos_gt_cnt1;
  assign bad_pos     = pos_zero || pos_gt_cnt;
  assign full        = (free_r == NULL_LINK) || ({1'b0, count_r} >= 9'(NODE_COUNT));

  // walk node: start node on the first step, then the link just read
  assign cur = first_r ? node_r : link_rdata;

  alm_link_store #(
    .NODE_COUNT (NODE_COUNT)
  ) u_links (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (link_req),
    .rdata (link_rdata)
  );

  alm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NODE_COUNT)
  ) u_values (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr[AW-1:0]),
    .wdata (val_r),
    .raddr (val_raddr[AW-1:0]),
    .rdata (val_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        case (cmd_r)
          CMD_INSERT: state_nxt = (bad_ins || full) ? S_DONE : S_INS_FREE;
          CMD_READ:   state_nxt = bad_pos ? S_DONE : S_WALK;
          CMD_REMOVE: begin
            if (bad_pos)      state_nxt = S_DONE;
            else if (pos_one) state_nxt = S_REM_HEAD;
            else              state_nxt = S_WALK;
          end
          default:    state_nxt = S_DONE;
        endcase
      end
      S_INS_FREE: state_nxt = pos_one ? S_DONE : S_WALK;
      S_WALK: begin
        if (steps_r == '0) begin
          case (cmd_r)
            CMD_INSERT: state_nxt = S_INS_PREV;
            CMD_REMOVE: state_nxt = S_REM_GONE;
            default:    state_nxt = S_RD_DATA;
          endcase
        end
      end
      S_INS_PREV: state_nxt = S_INS_LINK;
      S_INS_LINK: state_nxt = S_DONE;
      S_RD_DATA:  state_nxt = S_DONE;
      S_REM_HEAD: state_nxt = S_DONE;
      S_REM_GONE: state_nxt = S_REM_NEXT;
      S_REM_NEXT: state_nxt = S_REM_FREE;
      S_REM_FREE: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    head_nxt       = head_r;
    free_nxt       = free_r;
    count_nxt      = count_r;
    node_nxt       = node_r;
    gone_nxt       = gone_r;
    steps_nxt      = steps_r;
    first_nxt      = first_r;
    rd_nxt         = rd_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    link_req.we    = 1'b0;
    link_req.waddr = node_r;
    link_req.wdata = gone_r;
    link_req.raddr = node_r;
    val_we         = 1'b0;
    val_waddr      = free_r;
    val_raddr      = cur;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = cmd_t'(in_tuser);
          pos_nxt    = in_tdata[7:0];
          val_nxt    = in_tdata[39:8];
          rd_nxt     = '0;
          status_nxt = ST_OK;
        end
      end
      S_CHECK: begin
        node_nxt  = head_r;
        first_nxt = 1'b1;
        steps_nxt = (cmd_r == CMD_READ) ? pos_r - ptr_t'(1) : pos_r - ptr_t'(2);
        case (cmd_r)
          CMD_INSERT: begin
            gone_nxt       = free_r;
            link_req.raddr = free_r;
            if (bad_ins) begin
              status_nxt = ST_BAD_POS;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              val_we = 1'b1;
            end
          end
          CMD_READ: begin
            if (bad_pos) status_nxt = ST_BAD_POS;
          end
          CMD_REMOVE: begin
            gone_nxt       = head_r;
            link_req.raddr = head_r;
            if (bad_pos) status_nxt = ST_BAD_POS;
          end
          default: ;
        endcase
      end
      S_INS_FREE: begin
        free_nxt = link_rdata;
        if (pos_one) begin
          link_req.we    = 1'b1;
          link_req.waddr = gone_r;
          link_req.wdata = head_r;
          head_nxt       = gone_r;
          count_nxt      = count_r + ptr_t'(1);
        end
      end
      S_WALK: begin
        link_req.raddr = cur;
        node_nxt       = cur;
        first_nxt      = 1'b0;
        if (steps_r != '0) steps_nxt = steps_r - ptr_t'(1);
      end
      S_INS_PREV: begin
        // new node takes over the link of its predecessor
        link_req.we    = 1'b1;
        link_req.waddr = gone_r;
        link_req.wdata = link_rdata;
      end
      S_INS_LINK: begin
        link_req.we    = 1'b1;
        link_req.waddr = node_r;
        link_req.wdata = gone_r;
        count_nxt      = count_r + ptr_t'(1);
      end
      S_RD_DATA: begin
        rd_nxt = val_rdata;
      end
      S_REM_HEAD: begin
        head_nxt       = link_rdata;
        link_req.we    = 1'b1;
        link_req.waddr = gone_r;
        link_req.wdata = free_r;
        free_nxt       = gone_r;
        count_nxt      = count_r - ptr_t'(1);
      end
      S_REM_GONE: begin
        gone_nxt       = link_rdata;
        link_req.raddr = link_rdata;
      end
      S_REM_NEXT: begin
        link_req.we    = 1'b1;
        link_req.waddr = node_r;
        link_req.wdata = link_rdata;
      end
      S_REM_FREE: begin
        link_req.we    = 1'b1;
        link_req.waddr = gone_r;
        link_req.wdata = free_r;
        free_nxt       = gone_r;
        count_nxt      = count_r - ptr_t'(1);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, status_r, (count_r == '0), count_r, rd_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NULL_LINK;
      free_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    node_r     <= node_nxt;
    gone_r     <= gone_nxt;
    steps_r    <= steps_nxt;
    first_r    <= first_nxt;
    rd_r       <= rd_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
